>>> hdl/assert_macros.svh
// Assertion macros for the checker file of the HSV to RGB converter.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside of reset.
`define HSVC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// An implication checked at every rising clock edge outside of reset.
`define HSVC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> cons) \
    else $error(msg);

`endif

>>> hdl/hsvc_pkg.sv
// Shared constants, types and codes of the HSV to RGB converter.
// Depends on nothing; every module of the block refers to it by scoped names.
package hsvc_pkg;

  localparam int unsigned HueW   = 16;
  localparam int unsigned PctW   = 7;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned HmodW  = 9;
  localparam int unsigned OffW   = 6;
  localparam int unsigned SectW  = 3;

  // Stages from request to result strobe.
  localparam int unsigned PipeDepth = 7;

  localparam logic [PctW-1:0] PctFull = 7'd100;
  localparam logic [8:0]      HueModulus = 9'd360;

  // Reciprocals used in place of dividers, each exact over its input range.
  localparam logic [15:0] RecipHue360 = 16'd46603;  // >> 24, then one correction
  localparam logic [12:0] Recip100    = 13'd5243;   // >> 19, exact below 32768
  localparam logic [10:0] Recip60Hue  = 11'd1093;   // >> 16, exact below 360
  localparam logic [14:0] Recip60Ramp = 15'd17477;  // >> 20, exact below 16384

  typedef enum logic [SectW-1:0] {
    SECT_RED_GREEN_UP   = 3'd0,
    SECT_RED_DOWN       = 3'd1,
    SECT_GREEN_BLUE_UP  = 3'd2,
    SECT_GREEN_DOWN     = 3'd3,
    SECT_RED_UP         = 3'd4,
    SECT_BLUE_DOWN      = 3'd5
  } sector_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

endpackage

>>> hdl/hsvc_hue_split.sv
// Hue path of the converter: modulo 360, then sector and offset within it.
// Three register stages; depends on hsvc_pkg.
module hsvc_hue_split (
  input  logic                             clk_i,
  input  logic [hsvc_pkg::HueW-1:0]        hue_i,
  output hsvc_pkg::sector_e                sector_o,
  output logic [hsvc_pkg::OffW-1:0]        offset_o
);

  localparam int unsigned HueW  = hsvc_pkg::HueW;
  localparam int unsigned HmodW = hsvc_pkg::HmodW;
  localparam int unsigned OffW  = hsvc_pkg::OffW;

  logic [hsvc_pkg::HueW-1:0]  hue_q;
  logic [7:0]                 quot_q;
  logic [31:0]                quot_prod;
  logic [hsvc_pkg::HueW-1:0]  quot_times;
  logic [9:0]                 rem_raw;
  logic [hsvc_pkg::HmodW-1:0] hmod_d, hmod_q;
  logic [18:0]                sect_prod;
  logic [hsvc_pkg::SectW-1:0] sect_d;
  logic [hsvc_pkg::OffW-1:0]  off_d;
  logic [8:0]                 sect_times;
  hsvc_pkg::sector_e          sector_q;
  logic [hsvc_pkg::OffW-1:0]  offset_q;

  // The reciprocal underestimates, so the quotient is exact or one short.
  assign quot_prod = hue_i * hsvc_pkg::RecipHue360;

  always_ff @(posedge clk_i) begin
    hue_q  <= hue_i;
    quot_q <= quot_prod[31:24];
  end

  assign quot_times = HueW'(quot_q) * HueW'(hsvc_pkg::HueModulus);
  assign rem_raw    = 10'(hue_q - quot_times);

  always_comb begin
    if (rem_raw >= 10'(hsvc_pkg::HueModulus)) begin
      hmod_d = HmodW'(rem_raw - 10'(hsvc_pkg::HueModulus));
    end else begin
      hmod_d = HmodW'(rem_raw);
    end
  end

  always_ff @(posedge clk_i) begin
    hmod_q <= hmod_d;
  end

  assign sect_prod  = 19'(hmod_q) * 19'(hsvc_pkg::Recip60Hue);
  assign sect_d     = sect_prod[18:16];
  assign sect_times = 9'(sect_d) * 9'd60;
  assign off_d      = OffW'(hmod_q - sect_times);

  always_ff @(posedge clk_i) begin
    sector_q <= hsvc_pkg::sector_e'(sect_d);
    offset_q <= off_d;
  end

  assign sector_o = sector_q;
  assign offset_o = offset_q;

endmodule

>>> hdl/hsvc_level.sv
// Level path of the converter: clamps, then peak and floor channel levels.
// Three register stages; depends on hsvc_pkg.
module hsvc_level (
  input  logic                             clk_i,
  input  logic [hsvc_pkg::PctW-1:0]        saturation_i,
  input  logic [hsvc_pkg::PctW-1:0]        value_level_i,
  output logic [hsvc_pkg::ChanW-1:0]       peak_o,
  output logic [hsvc_pkg::ChanW-1:0]       low_o
);

  logic [hsvc_pkg::PctW-1:0]  sat_c, val_c;
  logic [14:0]                peak_num;
  logic [27:0]                peak_prod;
  logic [hsvc_pkg::ChanW-1:0] peak1_q, peak2_q, peak3_q;
  logic [hsvc_pkg::PctW-1:0]  inv_sat_q;
  logic [14:0]                low_num_q;
  logic [27:0]                low_prod;
  logic [hsvc_pkg::ChanW-1:0] low_q;

  assign sat_c = (saturation_i > hsvc_pkg::PctFull) ? hsvc_pkg::PctFull : saturation_i;
  assign val_c = (value_level_i > hsvc_pkg::PctFull) ? hsvc_pkg::PctFull : value_level_i;

  // value * 255 as a shift and subtract, then divided by 100.
  assign peak_num  = {val_c, 8'd0} - 15'(val_c);
  assign peak_prod = 28'(peak_num) * 28'(hsvc_pkg::Recip100);

  always_ff @(posedge clk_i) begin
    peak1_q   <= peak_prod[26:19];
    inv_sat_q <= hsvc_pkg::PctFull - sat_c;
  end

  always_ff @(posedge clk_i) begin
    peak2_q   <= peak1_q;
    low_num_q <= 15'(peak1_q) * 15'(inv_sat_q);
  end

  assign low_prod = 28'(low_num_q) * 28'(hsvc_pkg::Recip100);

  always_ff @(posedge clk_i) begin
    peak3_q <= peak2_q;
    low_q   <= low_prod[26:19];
  end

  assign peak_o = peak3_q;
  assign low_o  = low_q;

endmodule

>>> hdl/hsvc_mix.sv
// Ramp computation and sector channel selection of the converter.
// Two register stages; depends on hsvc_pkg.
module hsvc_mix (
  input  logic                             clk_i,
  input  hsvc_pkg::sector_e                sector_i,
  input  logic [hsvc_pkg::OffW-1:0]        offset_i,
  input  logic [hsvc_pkg::ChanW-1:0]       peak_i,
  input  logic [hsvc_pkg::ChanW-1:0]       low_i,
  output hsvc_pkg::rgb_t                   rgb_o
);

  hsvc_pkg::sector_e          sector_q;
  logic [hsvc_pkg::ChanW-1:0] peak_q, low_q, ramp;
  logic [13:0]                ramp_num_q;
  logic [27:0]                ramp_prod;
  logic [hsvc_pkg::ChanW-1:0] rise, fall;
  hsvc_pkg::rgb_t             rgb_d, rgb_q;

  always_ff @(posedge clk_i) begin
    sector_q   <= sector_i;
    peak_q     <= peak_i;
    low_q      <= low_i;
    ramp_num_q <= 14'(peak_i - low_i) * 14'(offset_i);
  end

  assign ramp_prod = 28'(ramp_num_q) * 28'(hsvc_pkg::Recip60Ramp);
  assign ramp      = ramp_prod[27:20];
  assign rise      = low_q + ramp;
  assign fall      = peak_q - ramp;

  always_comb begin
    case (sector_q)
      hsvc_pkg::SECT_RED_GREEN_UP: begin
        rgb_d = '{red: peak_q, green: rise, blue: low_q};
      end
      hsvc_pkg::SECT_RED_DOWN: begin
        rgb_d = '{red: fall, green: peak_q, blue: low_q};
      end
      hsvc_pkg::SECT_GREEN_BLUE_UP: begin
        rgb_d = '{red: low_q, green: peak_q, blue: rise};
      end
      hsvc_pkg::SECT_GREEN_DOWN: begin
        rgb_d = '{red: low_q, green: fall, blue: peak_q};
      end
      hsvc_pkg::SECT_RED_UP: begin
        rgb_d = '{red: rise, green: low_q, blue: peak_q};
      end
      default: begin
        rgb_d = '{red: peak_q, green: low_q, blue: fall};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign rgb_o = rgb_q;

endmodule

>>> hdl/hsvc_scale.sv
// Brightness scaling of the three channels: multiply, then divide by 100.
// Two register stages; depends on hsvc_pkg.
module hsvc_scale (
  input  logic                             clk_i,
  input  hsvc_pkg::rgb_t                   rgb_i,
  input  logic [hsvc_pkg::PctW-1:0]        bright_i,
  output hsvc_pkg::rgb_t                   rgb_o
);

  logic [14:0]    red_num_q, green_num_q, blue_num_q;
  logic [27:0]    red_prod, green_prod, blue_prod;
  hsvc_pkg::rgb_t rgb_q;

  always_ff @(posedge clk_i) begin
    red_num_q   <= 15'(rgb_i.red)   * 15'(bright_i);
    green_num_q <= 15'(rgb_i.green) * 15'(bright_i);
    blue_num_q  <= 15'(rgb_i.blue)  * 15'(bright_i);
  end

  assign red_prod   = 28'(red_num_q)   * 28'(hsvc_pkg::Recip100);
  assign green_prod = 28'(green_num_q) * 28'(hsvc_pkg::Recip100);
  assign blue_prod  = 28'(blue_num_q)  * 28'(hsvc_pkg::Recip100);

  always_ff @(posedge clk_i) begin
    rgb_q.red   <= red_prod[26:19];
    rgb_q.green <= green_prod[26:19];
    rgb_q.blue  <= blue_prod[26:19];
  end

  assign rgb_o = rgb_q;

endmodule

>>> hdl/hsv_to_rgb_converter.sv
// HSV to RGB converter, top level. The done strobe is timed by the seven-stage
// arithmetic pipeline, along which a valid bit for each request is shifted.
// Throughput is one request per cycle; busy never rises and the receiver cannot stall.
// Reset clears the valid bits and sets brightness to 100 percent.
// Depends on hsvc_pkg, hsvc_hue_split, hsvc_level, hsvc_mix and hsvc_scale.
module hsv_to_rgb_converter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [hsvc_pkg::HueW-1:0]        hue_i,
  input  logic [hsvc_pkg::PctW-1:0]        saturation_i,
  input  logic [hsvc_pkg::PctW-1:0]        value_level_i,
  input  logic                             cfg_we_i,
  input  logic [hsvc_pkg::PctW-1:0]        cfg_wdata_i,
  output logic                             done_o,
  output logic [hsvc_pkg::ChanW-1:0]       red_out_o,
  output logic [hsvc_pkg::ChanW-1:0]       green_out_o,
  output logic [hsvc_pkg::ChanW-1:0]       blue_out_o
);

  logic [hsvc_pkg::PipeDepth-1:0] valid_d, valid_q;
  logic [hsvc_pkg::PctW-1:0]      bright_d, bright_q, bright_eff;
  hsvc_pkg::sector_e              sector;
  logic [hsvc_pkg::OffW-1:0]      offset;
  logic [hsvc_pkg::ChanW-1:0]     peak, low;
  hsvc_pkg::rgb_t                 rgb_mix, rgb_out;

  assign busy = 1'b0;

  assign valid_d  = {valid_q[hsvc_pkg::PipeDepth-2:0], start & ~busy};
  assign bright_d = cfg_we_i ? cfg_wdata_i : bright_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      bright_q <= hsvc_pkg::PctFull;
    end else begin
      valid_q  <= valid_d;
      bright_q <= bright_d;
    end
  end

  // Register values above 100 percent act as 100 percent.
  assign bright_eff = (bright_q > hsvc_pkg::PctFull) ? hsvc_pkg::PctFull : bright_q;

  hsvc_hue_split u_hue (
    .clk_i    (clk_i),
    .hue_i    (hue_i),
    .sector_o (sector),
    .offset_o (offset)
  );

  hsvc_level u_level (
    .clk_i         (clk_i),
    .saturation_i  (saturation_i),
    .value_level_i (value_level_i),
    .peak_o        (peak),
    .low_o         (low)
  );

  hsvc_mix u_mix (
    .clk_i    (clk_i),
    .sector_i (sector),
    .offset_i (offset),
    .peak_i   (peak),
    .low_i    (low),
    .rgb_o    (rgb_mix)
  );

  hsvc_scale u_scale (
    .clk_i    (clk_i),
    .rgb_i    (rgb_mix),
    .bright_i (bright_eff),
    .rgb_o    (rgb_out)
  );

  assign done_o      = valid_q[hsvc_pkg::PipeDepth-1];
  assign red_out_o   = rgb_out.red;
  assign green_out_o = rgb_out.green;
  assign blue_out_o  = rgb_out.blue;

endmodule

>>> hdl/hsvc_checker.sv
// Port-level checker of the HSV to RGB converter, bound to the top level.
// Depends on hsvc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hsvc_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  input  logic                             busy,
  input  logic [hsvc_pkg::PctW-1:0]        saturation_i,
  input  logic [hsvc_pkg::PctW-1:0]        value_level_i,
  input  logic                             done_o,
  input  logic [hsvc_pkg::ChanW-1:0]       red_out_o,
  input  logic [hsvc_pkg::ChanW-1:0]       green_out_o,
  input  logic [hsvc_pkg::ChanW-1:0]       blue_out_o
);

  `HSVC_ASSERT(a_never_busy, clk_i, rst_ni, !busy, "converter reported busy")
  `HSVC_ASSERT_IMP(a_fixed_latency, clk_i, rst_ni, start && !busy, ##7 done_o, "result strobe missing seven cycles after request")
  // A zero value level yields black whatever the hue and saturation.
  `HSVC_ASSERT_IMP(a_black, clk_i, rst_ni, start && !busy && value_level_i == '0, ##7 (red_out_o == '0 && green_out_o == '0 && blue_out_o == '0), "zero value level did not give black")
  // Zero saturation yields a gray: all three channels equal.
  `HSVC_ASSERT_IMP(a_gray, clk_i, rst_ni, start && !busy && saturation_i == '0, ##7 (red_out_o == green_out_o && green_out_o == blue_out_o), "zero saturation did not give gray")

endmodule

bind hsv_to_rgb_converter hsvc_checker u_hsvc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .saturation_i  (saturation_i),
  .value_level_i (value_level_i),
  .done_o        (done_o),
  .red_out_o     (red_out_o),
  .green_out_o   (green_out_o),
  .blue_out_o    (blue_out_o)
);

>>> tb/sv/tb_top.sv
// Self-checking testbench for the HSV to RGB converter top level.
// Depends on hsvc_pkg and hsv_to_rgb_converter; needs no files or arguments.
`timescale 1ns / 100ps

class pixel_scoreboard;
  hsvc_pkg::rgb_t          pending_rgb[$];
  logic [hsvc_pkg::PctW-1:0] brightness;
  int unsigned             mismatches;
  int unsigned             pixels_checked;

  function new();
    brightness     = hsvc_pkg::PctFull;
    mismatches     = 0;
    pixels_checked = 0;
  endfunction

  function automatic logic [hsvc_pkg::PctW-1:0] clamp_pct(logic [hsvc_pkg::PctW-1:0] pct);
    return (pct > hsvc_pkg::PctFull) ? hsvc_pkg::PctFull : pct;
  endfunction

  function automatic logic [hsvc_pkg::ChanW-1:0] dim(int unsigned chan,
                                                    int unsigned bright);
    return hsvc_pkg::ChanW'((chan * bright) / 100);
  endfunction

  // Integer form of the usual six-sector HSV conversion, floors throughout.
  function automatic hsvc_pkg::rgb_t convert_pixel(logic [hsvc_pkg::HueW-1:0] hue,
                                                   logic [hsvc_pkg::PctW-1:0] sat,
                                                   logic [hsvc_pkg::PctW-1:0] val);
    int unsigned      hue_mod;
    int unsigned      sat_c;
    int unsigned      val_c;
    int unsigned      bright_c;
    int unsigned      peak;
    int unsigned      low_lvl;
    int unsigned      offs;
    int unsigned      ramp;
    int unsigned      red;
    int unsigned      green;
    int unsigned      blue;
    hsvc_pkg::sector_e sect;
    hsvc_pkg::rgb_t   rgb;
    hue_mod  = hue % 360;
    sat_c    = clamp_pct(sat);
    val_c    = clamp_pct(val);
    bright_c = clamp_pct(brightness);
    peak     = (val_c * 255) / 100;
    low_lvl  = (peak * (100 - sat_c)) / 100;
    sect     = hsvc_pkg::sector_e'(hue_mod / 60);
    offs     = hue_mod % 60;
    ramp     = ((peak - low_lvl) * offs) / 60;
    case (sect)
      hsvc_pkg::SECT_RED_GREEN_UP: begin
        red = peak;           green = low_lvl + ramp; blue = low_lvl;
      end
      hsvc_pkg::SECT_RED_DOWN: begin
        red = peak - ramp;    green = peak;           blue = low_lvl;
      end
      hsvc_pkg::SECT_GREEN_BLUE_UP: begin
        red = low_lvl;        green = peak;           blue = low_lvl + ramp;
      end
      hsvc_pkg::SECT_GREEN_DOWN: begin
        red = low_lvl;        green = peak - ramp;    blue = peak;
      end
      hsvc_pkg::SECT_RED_UP: begin
        red = low_lvl + ramp; green = low_lvl;        blue = peak;
      end
      default: begin
        red = peak;           green = low_lvl;        blue = peak - ramp;
      end
    endcase
    rgb.red   = dim(red, bright_c);
    rgb.green = dim(green, bright_c);
    rgb.blue  = dim(blue, bright_c);
    return rgb;
  endfunction

  function void note_request(logic [hsvc_pkg::HueW-1:0] hue,
                             logic [hsvc_pkg::PctW-1:0] sat,
                             logic [hsvc_pkg::PctW-1:0] val);
    pending_rgb.push_back(convert_pixel(hue, sat, val));
  endfunction

  function void check_pixel(logic [hsvc_pkg::ChanW-1:0] red,
                            logic [hsvc_pkg::ChanW-1:0] green,
                            logic [hsvc_pkg::ChanW-1:0] blue);
    hsvc_pkg::rgb_t want;
    if (pending_rgb.size() == 0) begin
      $error("Pixel result with no request outstanding: r=%0d g=%0d b=%0d",
             red, green, blue);
      mismatches++;
      return;
    end
    want = pending_rgb.pop_front();
    pixels_checked++;
    if (red !== want.red) begin
      $error("red_out: expected %0d, got %0d", want.red, red);
      mismatches++;
    end
    if (green !== want.green) begin
      $error("green_out: expected %0d, got %0d", want.green, green);
      mismatches++;
    end
    if (blue !== want.blue) begin
      $error("blue_out: expected %0d, got %0d", want.blue, blue);
      mismatches++;
    end
  endfunction

  function int unsigned outstanding();
    return pending_rgb.size();
  endfunction
endclass

module tb_top;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhasePixels  = 130;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [hsvc_pkg::HueW-1:0]     hue_i = '0;
  logic [hsvc_pkg::PctW-1:0]     saturation_i = '0;
  logic [hsvc_pkg::PctW-1:0]     value_level_i = '0;
  logic                          cfg_we_i = 1'b0;
  logic [hsvc_pkg::PctW-1:0]     cfg_wdata_i = '0;
  logic                          done_o;
  logic [hsvc_pkg::ChanW-1:0]    red_out_o;
  logic [hsvc_pkg::ChanW-1:0]    green_out_o;
  logic [hsvc_pkg::ChanW-1:0]    blue_out_o;

  int unsigned     cycle_count = 0;
  pixel_scoreboard rgb_board = new();

  hsv_to_rgb_converter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .hue_i         (hue_i),
    .saturation_i  (saturation_i),
    .value_level_i (value_level_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Requests and results are sampled with their pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) rgb_board.note_request(hue_i, saturation_i, value_level_i);
      if (done_o) rgb_board.check_pixel(red_out_o, green_out_o, blue_out_o);
    end
  end

  task automatic send_pixel(input logic [hsvc_pkg::HueW-1:0] hue,
                            input logic [hsvc_pkg::PctW-1:0] sat,
                            input logic [hsvc_pkg::PctW-1:0] val,
                            input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    hue_i         <= hue;
    saturation_i  <= sat;
    value_level_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain_pixels();
    start <= 1'b0;
    @(posedge clk_i);
    while (rgb_board.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic set_brightness(input logic [hsvc_pkg::PctW-1:0] pct);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= pct;
    @(posedge clk_i);
    rgb_board.brightness = pct;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [hsvc_pkg::PctW-1:0] pick_pct();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return hsvc_pkg::PctFull;
      2:       return hsvc_pkg::PctW'($urandom_range(101, 127));
      default: return hsvc_pkg::PctW'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [hsvc_pkg::HueW-1:0] pick_hue();
    case ($urandom_range(0, 3))
      0:       return hsvc_pkg::HueW'($urandom_range(0, 359));
      1:       return hsvc_pkg::HueW'(60 * $urandom_range(0, 5) + 59 * $urandom_range(0, 1));
      default: return hsvc_pkg::HueW'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    logic [hsvc_pkg::PctW-1:0] phase_bright[PhaseCount];
    logic [hsvc_pkg::HueW-1:0] dir_hue[22];
    logic [hsvc_pkg::PctW-1:0] dir_sat[22];
    logic [hsvc_pkg::PctW-1:0] dir_val[22];
    bit                        idle_on;
    int unsigned               gap;

    // Sector edges, hue wrap, clamped saturation and value, all-zero and all-one fields.
    dir_hue = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300,
                359, 360, 65535, 65535, 1000, 30, 90, 200, 45, 330, 21600};
    dir_sat = '{100, 100, 100, 50, 100, 30, 100, 0, 100, 75, 100,
                100, 100, 127, 101, 0, 127, 0, 101, 100, 1, 50};
    dir_val = '{100, 100, 100, 100, 100, 80, 100, 100, 100, 60, 100,
                100, 100, 127, 101, 0, 0, 127, 55, 1, 100, 50};
    phase_bright = '{7'd0, 7'd127, 7'd1, 7'd101, 7'd50, 7'd99,
                     hsvc_pkg::PctW'($urandom_range(0, 127)), hsvc_pkg::PctFull};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass at the reset brightness, requests back to back.
    for (int i = 0; i < 22; i++) send_pixel(dir_hue[i], dir_sat[i], dir_val[i], 0);
    drain_pixels();

    for (int p = 0; p < PhaseCount; p++) begin
      set_brightness(phase_bright[p]);
      idle_on = 1'b1;
      for (int n = 0; n < PhasePixels; n++) begin
        // Idling is switched on and off in stretches; the last phase runs flat out.
        if (n % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
        gap = 0;
        if (idle_on && p != PhaseCount - 1 && $urandom_range(0, 3) == 0)
          gap = $urandom_range(1, 16);
        send_pixel(pick_hue(), pick_pct(), pick_pct(), gap);
      end
      drain_pixels();
    end

    repeat (hsvc_pkg::PipeDepth + 4) @(posedge clk_i);

    $display("Checked %0d pixels across %0d brightness settings, including 0, 127 and 101.",
             rgb_board.pixels_checked, PhaseCount + 1);
    $display("Hue wrap, all six sectors and over-range saturation and value were exercised.");
    if (rgb_board.mismatches == 0 && rgb_board.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
